>>> rtl/dqi_pkg.sv
// Package: shared widths, state type, pipeline tag and basis ROM for the dequantizer/IDCT.
`default_nettype none
package dqi_pkg;

  localparam int NPOS      = 64;
  localparam int IDX_W     = 6;
  localparam int COEF_W    = 12;
  localparam int QV_W      = 8;
  localparam int CORR_W    = 16;
  localparam int BUF_W     = 24;
  localparam int TMP_W     = 42;
  localparam int A_W       = 16;
  localparam int PROD_W    = TMP_W + A_W;
  localparam int ACC_W     = 64;
  localparam int SEQ_W     = 10;
  localparam int FRAC_BITS = 4;
  localparam int SAMPLE_W  = 16;

  localparam logic [0:0] OP_TABLE = 1'b0;
  localparam logic [0:0] OP_COEF  = 1'b1;

  // Last issue at 511; its result passes the MAC tag registers t1, t2 and t3 before the drain ends at DRAIN_END
  localparam logic [SEQ_W-1:0] ISSUE_END = 10'd512;
  localparam logic [SEQ_W-1:0] DRAIN_END = 10'd515;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DQ,
    ST_ROW,
    ST_COL
  } state_t;

  // Tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // Q14 basis entry c(u)*cos(pi*u*(2x+1)/16)
  function automatic logic signed [A_W-1:0] basis(input logic [2:0] u, input logic [2:0] x);
    logic [7:0]  prod;
    logic [4:0]  k;
    logic [3:0]  m;
    logic [14:0] mag;
    logic        neg;
    prod = {5'b0, u} * {4'b0, x, 1'b1};
    k    = prod[4:0];
    m    = k[3] ? (4'd8 - {1'b0, k[2:0]}) : {1'b0, k[2:0]};
    neg  = (k[4:3] == 2'd1) || (k[4:3] == 2'd2);
    if (u == 3'd0) begin
      mag = 15'd11585;
    end else begin
      case (m)
        4'd0:    mag = 15'd16384;
        4'd1:    mag = 15'd16069;
        4'd2:    mag = 15'd15137;
        4'd3:    mag = 15'd13623;
        4'd4:    mag = 15'd11585;
        4'd5:    mag = 15'd9102;
        4'd6:    mag = 15'd6270;
        4'd7:    mag = 15'd3196;
        default: mag = 15'd0;
      endcase
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage
`default_nettype wire

>>> rtl/dqi_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dqi_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/dqi_mac.sv
// Pipelined MAC: multiply, accumulate the terms from first to last tag, present the sum.
`default_nettype none
module dqi_mac (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dqi_pkg::tag_t                tag_i,
  input  wire logic signed [dqi_pkg::A_W-1:0]   a_i,
  input  wire logic signed [dqi_pkg::TMP_W-1:0] opnd_i,
  output logic                              res_valid,
  output logic signed [dqi_pkg::ACC_W-1:0]  res_acc,
  output logic [dqi_pkg::IDX_W-1:0]         res_idx
);
  import dqi_pkg::*;

  tag_t                     t1_r, t2_r, t3_r;
  logic signed [A_W-1:0]    a1_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [ACC_W-1:0]  acc_r;

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t1_r <= tag_i;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
  end

  // Datapath: operand arrives with t1 (memory latency)
  always_ff @(posedge clk) begin
    a1_r <= a_i;
    p_r  <= opnd_i * a1_r;
    if (t2_r.valid) begin
      acc_r <= (t2_r.first ? '0 : acc_r) + ACC_W'(p_r);
    end
  end

  assign res_valid = t3_r.valid && t3_r.last;
  assign res_acc   = acc_r;
  assign res_idx   = t3_r.idx;

endmodule
`default_nettype wire

>>> rtl/dequant_idct_8x8_top.sv
// Top level: command port, dequantizer, row/column IDCT sequencer and output register.
//
// Each command is one transfer on start while busy is low. A table write is stored
// straight from the command ports; a coefficient passes a table read, then dequantize
// and store. The 64th coefficient starts the transform: a row pass and a column pass,
// each 512 steps of one shared multiply-accumulate over the coefficient and
// intermediate memories plus a drain of the MAC pipeline; busy stays high throughout.
// The 64 samples leave during the column pass, each on the out_ ports for one cycle
// with out_strobe high; the receiver cannot stall them. Memories hold no reset value:
// a coefficient whose table entry was never written gives an undefined result.
`default_nettype none
module dequant_idct_8x8_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_operation,
  input  wire logic [dqi_pkg::IDX_W-1:0]          in_table_index,
  input  wire logic [dqi_pkg::QV_W-1:0]           in_table_value,
  input  wire logic signed [dqi_pkg::COEF_W-1:0]  in_coefficient,
  input  wire logic signed [dqi_pkg::CORR_W-1:0]  in_correction,
  output logic                                    out_strobe,
  output logic signed [dqi_pkg::SAMPLE_W-1:0]     out_sample,
  output logic [dqi_pkg::IDX_W-1:0]               out_sample_index,
  output logic                                    out_last
);
  import dqi_pkg::*;

  state_t                   state_r, state_nxt;
  logic [SEQ_W-1:0]         seq_r, seq_nxt;
  logic [IDX_W-1:0]         cnt_r, cnt_nxt;
  logic signed [COEF_W-1:0] coef_r;
  logic signed [CORR_W-1:0] corr_r;
  logic                     accept;

  logic                     q_we;
  logic [QV_W-1:0]          q_rdata;
  logic                     c_we;
  logic [BUF_W-1:0]         c_wdata, c_rdata;
  logic [IDX_W-1:0]         c_raddr;
  logic                     t_we;
  logic [TMP_W-1:0]         t_rdata;
  logic [IDX_W-1:0]         t_raddr;

  tag_t                     tag;
  logic signed [A_W-1:0]    a_val;
  logic signed [TMP_W-1:0]  opnd;
  logic                     res_valid;
  logic signed [ACC_W-1:0]  res_acc;
  logic [IDX_W-1:0]         res_idx;

  logic [IDX_W-1:0]         o;
  logic [2:0]               j;
  logic                     issue;

  logic signed [COEF_W+QV_W:0]   prod_dq;
  logic signed [BUF_W:0]         f_dq;
  logic [ACC_W-1:0]              mag;
  logic [ACC_W-1:0]              qsum;
  logic signed [SAMPLE_W-1:0]    sample_nxt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      coef_r <= in_coefficient;
      corr_r <= in_correction;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seq_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    seq_nxt   = seq_r;
    cnt_nxt   = cnt_r;
    q_we      = 1'b0;
    c_we      = 1'b0;
    issue     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_TABLE) begin
            q_we = 1'b1;
          end else begin
            state_nxt = ST_DQ;
          end
        end
      end
      ST_DQ: begin
        c_we    = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        seq_nxt = '0;
        state_nxt = (cnt_r == IDX_W'(NPOS - 1)) ? ST_ROW : ST_IDLE;
      end
      ST_ROW, ST_COL: begin
        issue   = (seq_r < ISSUE_END);
        seq_nxt = seq_r + 1'b1;
        if (seq_r == DRAIN_END) begin
          seq_nxt   = '0;
          state_nxt = (state_r == ST_ROW) ? ST_COL : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Dequantize: coefficient * step * 2^FRAC + correction, saturate to buffer width
  always_comb begin
    prod_dq = coef_r * $signed({1'b0, q_rdata});
    f_dq    = (BUF_W+1)'(prod_dq) * (BUF_W+1)'(2 ** FRAC_BITS) + (BUF_W+1)'(corr_r);
    if (f_dq > $signed((BUF_W+1)'(2 ** (BUF_W-1) - 1))) begin
      c_wdata = {1'b0, {(BUF_W-1){1'b1}}};
    end else if (f_dq < -$signed((BUF_W+1)'(2 ** (BUF_W-1)))) begin
      c_wdata = {1'b1, {(BUF_W-1){1'b0}}};
    end else begin
      c_wdata = f_dq[BUF_W-1:0];
    end
  end

  // Step addressing: o is the output position, j the summation index
  assign o = seq_r[8:3];
  assign j = seq_r[2:0];

  always_comb begin
    c_raddr = {o[5:3], j};
    t_raddr = {j, o[2:0]};
    if (state_r == ST_ROW) begin
      a_val = basis(j, o[2:0]);
    end else begin
      a_val = basis(j, o[5:3]);
    end
    tag.valid = issue;
    tag.first = (j == 3'd0);
    tag.last  = (j == 3'd7);
    tag.idx   = o;
    opnd      = (state_r == ST_ROW) ? TMP_W'($signed(c_rdata)) : $signed(t_rdata);
  end

  assign t_we = res_valid && (state_r == ST_ROW);

  dqi_ram #(.Width(QV_W), .Depth(NPOS)) u_quant_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (in_table_index),
    .wdata (in_table_value),
    .raddr (cnt_r),
    .rdata (q_rdata)
  );

  dqi_ram #(.Width(BUF_W), .Depth(NPOS)) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (cnt_r),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  dqi_ram #(.Width(TMP_W), .Depth(NPOS)) u_tmp_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (res_idx),
    .wdata (res_acc[TMP_W-1:0]),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  dqi_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (tag),
    .a_i       (a_val),
    .opnd_i    (opnd),
    .res_valid (res_valid),
    .res_acc   (res_acc),
    .res_idx   (res_idx)
  );

  // Scale by 2/(8*2^28): round half away from zero, then saturate
  always_comb begin
    mag  = res_acc[ACC_W-1] ? ACC_W'(-res_acc) : ACC_W'(res_acc);
    qsum = (mag + ACC_W'(64'd1 << 29)) >> 30;
    if (res_acc[ACC_W-1]) begin
      sample_nxt = (qsum > ACC_W'(32768)) ? -16'sd32768 : -$signed(qsum[SAMPLE_W-1:0]);
    end else begin
      sample_nxt = (qsum > ACC_W'(32767)) ? 16'sd32767 : $signed(qsum[SAMPLE_W-1:0]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= res_valid && (state_r == ST_COL);
    end
  end

  always_ff @(posedge clk) begin
    out_sample       <= sample_nxt;
    out_sample_index <= res_idx;
    out_last         <= (res_idx == IDX_W'(NPOS - 1));
  end

endmodule
`default_nettype wire
